// ----- hdl/pnd_pkg.sv -----
// ----------------------------------------------------------------------------
// pnd_pkg
// Shared types and constants of the point to polyline distance block.
// ----------------------------------------------------------------------------
package pnd_pkg;

    // Position rotation
    localparam int ROT_STEPS  = 30;
    localparam int STEP_W     = 5;
    localparam int GUARD_BITS = 16;
    localparam int ROT_W      = 50;   // rotation datapath width, guard bits included
    localparam int ANG_W      = 34;   // residual angle width
    localparam logic [29:0] GAIN_Q30 = 30'h26DD3B6A;

    localparam logic [31:0] ROT_ANGLE [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Datapath widths
    localparam int POS_W  = 34;   // query and projected position
    localparam int DIF_W  = 35;   // coordinate differences, multiplier operands
    localparam int PROD_W = 70;   // product and unsigned squared sums
    localparam int ACC_W  = 71;   // signed accumulator

    // Divide / square root unit
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 35;
    localparam int ROOT_W     = 35;
    localparam int CNT_W      = 6;

    typedef enum logic {
        DS_DIV  = 1'b0,
        DS_SQRT = 1'b1
    } ds_mode_t;

    typedef struct packed {
        logic     start;
        ds_mode_t mode;
    } ds_ctrl_t;

    // Commands and clamp codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] KIND_INTERIOR = 2'd0;
    localparam logic [1:0] KIND_START    = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

endpackage

// ----- hdl/pnd_if.sv -----
// ----------------------------------------------------------------------------
// pnd_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface pnd_item_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [10:0]        point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        query_radius;
    logic signed [31:0] query_angle;

    modport source (
        output valid, cmd, point_index, point_x, point_y, query_radius, query_angle,
        input  ready
    );
    modport sink (
        input  valid, cmd, point_index, point_x, point_y, query_radius, query_angle,
        output ready
    );
endinterface

interface pnd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;
    logic [10:0] segment_start;
    logic [1:0]  clamp_kind;
    logic        error;

    modport source (
        output valid, distance, segment_start, clamp_kind, error,
        input  ready
    );
    modport sink (
        input  valid, distance, segment_start, clamp_kind, error,
        output ready
    );
endinterface

// ----- hdl/pnd_ram.sv -----
// ----------------------------------------------------------------------------
// pnd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pnd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/pnd_cordic.sv -----
// ----------------------------------------------------------------------------
// pnd_cordic
// Iterative rotation: one shift-add step per cycle, 30 steps per position.
// ----------------------------------------------------------------------------
module pnd_cordic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [pnd_pkg::ROT_W-1:0] x0,
    input  logic signed [pnd_pkg::ANG_W-1:0] angle,
    output logic                             done,
    output logic signed [pnd_pkg::POS_W-1:0] qx,
    output logic signed [pnd_pkg::POS_W-1:0] qy
);
    import pnd_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [ROT_W-1:0] x_reg;
    logic signed [ROT_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;

    logic signed [ROT_W-1:0] x_sh;
    logic signed [ROT_W-1:0] y_sh;
    logic signed [ANG_W-1:0] step_ang;
    logic signed [ROT_W-1:0] x_rnd;
    logic signed [ROT_W-1:0] y_rnd;

    assign x_sh     = x_reg >>> step_reg;
    assign y_sh     = y_reg >>> step_reg;
    assign step_ang = $signed({2'b00, ROT_ANGLE[step_reg]});

    // round to nearest, floor shift out the guard bits
    assign x_rnd = x_reg + (ROT_W'(1) <<< (GUARD_BITS - 1));
    assign y_rnd = y_reg + (ROT_W'(1) <<< (GUARD_BITS - 1));
    assign qx    = x_rnd[GUARD_BITS +: POS_W];
    assign qy    = y_rnd[GUARD_BITS +: POS_W];
    assign done  = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(ROT_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x0;
            y_reg <= '0;
            z_reg <= angle;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - step_ang;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + step_ang;
            end
        end
    end
endmodule

// ----- hdl/pnd_divsqrt.sv -----
// ----------------------------------------------------------------------------
// pnd_divsqrt
// Shared restoring unit: fraction divide (32 steps) or floor square root
// (35 steps), one compare-subtract per cycle.
// ----------------------------------------------------------------------------
module pnd_divsqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pnd_pkg::ds_ctrl_t                 ctrl,
    input  logic [pnd_pkg::PROD_W-1:0]        num,
    input  logic [pnd_pkg::PROD_W-1:0]        den,
    output logic                              done,
    output logic [pnd_pkg::ROOT_W-1:0]        root
);
    import pnd_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    ds_mode_t          mode_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] vsh_reg;
    logic [PROD_W-1:0] den_reg;
    logic [ROOT_W-1:0] q_reg;

    logic [PROD_W-1:0] a_val;
    logic [PROD_W-1:0] b_val;
    logic              ge;
    logic              last;

    always_comb
    begin
        if (mode_reg == DS_DIV)
        begin
            a_val = {rem_reg[PROD_W-2:0], 1'b0};
            b_val = den_reg;
            last  = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        end
        else
        begin
            // bring down the next two radicand bits, trial is 4*root+1
            a_val = {rem_reg[PROD_W-3:0], vsh_reg[PROD_W-1 -: 2]};
            b_val = {{(PROD_W-ROOT_W-2){1'b0}}, q_reg, 2'b01};
            last  = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
        end
        ge = (a_val >= b_val);
    end

    assign done = done_reg;
    assign root = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mode_reg <= ctrl.mode;
            den_reg  <= den;
            q_reg    <= '0;
            if (ctrl.mode == DS_DIV)
            begin
                rem_reg <= num;
                vsh_reg <= '0;
            end
            else
            begin
                rem_reg <= '0;
                vsh_reg <= num;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (a_val - b_val) : a_val;
            q_reg   <= {q_reg[ROOT_W-2:0], ge};
            vsh_reg <= vsh_reg << 2;
        end
    end
endmodule

// ----- hdl/polyline_nearest_distance_top.sv -----
// ----------------------------------------------------------------------------
// polyline_nearest_distance_top
// Distance from a polar query position to a loaded polyline, Q16.16.
// ----------------------------------------------------------------------------
// Input channel "items" (valid/ready): cmd 0 writes point (point_x, point_y)
// into slot point_index and gives no result; cmd 1 runs a query for
// (query_radius, query_angle). Result channel "results": distance,
// segment_start, clamp_kind, error. Register point_count is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this. A load leaves ready high. A query
// holds ready low until its result is in the output register: it does the
// gain multiply, the rotation, the scan of every second point, the neighbour
// pair, the segment setup, the divide, the offsets, the final squared
// distance and the square root, then loads the output register. A clamped
// segment skips the divide and the offsets. The scan rate is set by the one
// shared multiplier (two squares per point) and the registered table read.
// A count below two gives an error result without a scan.
// The result waits in the output register while the receiver stalls; the
// next query may start, and holds at its end until the register frees up.
// Reset clears point_count and the control state; table contents stay
// undefined until loaded.
// ----------------------------------------------------------------------------
module polyline_nearest_distance_top #(
    parameter int MAX_POINTS = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [11:0]   cfg_wdata,
    pnd_item_if.sink      items,
    pnd_result_if.source  results
);
    import pnd_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 2;
    localparam int NW = (CW > 12) ? CW : 12;

    typedef enum logic [21:0] {
        ST_IDLE = 22'b1 << 0,
        ST_GAIN = 22'b1 << 1,
        ST_ROT  = 22'b1 << 2,
        ST_RD   = 22'b1 << 3,
        ST_LD   = 22'b1 << 4,
        ST_MX   = 22'b1 << 5,
        ST_MY   = 22'b1 << 6,
        ST_EV   = 22'b1 << 7,
        ST_ARD  = 22'b1 << 8,
        ST_ALD  = 22'b1 << 9,
        ST_BLD  = 22'b1 << 10,
        ST_DIF  = 22'b1 << 11,
        ST_P1   = 22'b1 << 12,
        ST_P2   = 22'b1 << 13,
        ST_P3   = 22'b1 << 14,
        ST_P4   = 22'b1 << 15,
        ST_CLS  = 22'b1 << 16,
        ST_DIV  = 22'b1 << 17,
        ST_OFX  = 22'b1 << 18,
        ST_OFY  = 22'b1 << 19,
        ST_SQRT = 22'b1 << 20,
        ST_OUT  = 22'b1 << 21
    } state_t;

    // what the squared-distance sequence is measuring
    typedef enum logic [1:0] {
        CTX_SCAN = 2'd0,
        CTX_LO   = 2'd1,
        CTX_HI   = 2'd2,
        CTX_FIN  = 2'd3
    } ctx_t;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;

    logic [11:0]   point_count_reg;
    logic          res_valid_reg;
    logic [31:0]   res_dist_reg;
    logic [10:0]   res_seg_reg;
    logic [1:0]    res_kind_reg;
    logic          res_err_reg;

    logic [30:0]              radius_reg;
    logic signed [31:0]       angle_reg;
    logic [CW-1:0]            n_reg;
    logic [CW-1:0]            addr_reg;
    logic [CW-1:0]            imin_reg;
    logic [CW-1:0]            il_reg;
    logic signed [POS_W-1:0]  qx_reg, qy_reg;
    logic [PROD_W-1:0]        best_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  dot_reg;
    logic signed [DIF_W-1:0]  ox_reg, oy_reg;
    logic signed [31:0]       ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [32:0]       sx_reg, sy_reg;
    logic [31:0]              t_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic [1:0]               kind_reg;
    logic                     pend_err_reg;
    logic [31:0]              pend_dist_reg;

    // table
    logic            in_xfer;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [63:0]     ram_rdata;
    logic signed [31:0] rd_x, rd_y;

    // point count in use
    logic [NW-1:0]   pc_w;
    logic [NW-1:0]   pc_cap;
    logic [CW-1:0]   n_val;

    // shared multiplier
    logic signed [DIF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // position setup
    logic signed [ANG_W-1:0]  ang_w;
    logic signed [ANG_W-1:0]  ang_red;
    logic                     flip;
    logic signed [ROT_W-1:0]  x0_pos;
    logic signed [ROT_W-1:0]  x0;
    logic                     rot_done;
    logic signed [POS_W-1:0]  rot_qx, rot_qy;

    // scan decisions
    logic [CW-1:0]  nxt_addr;
    logic           better;
    logic [CW-1:0]  new_imin;
    logic           scan_end;

    // projection
    logic signed [PROD_W-1:0] off_w;
    logic signed [POS_W-1:0]  off;
    logic                     dot_le0;
    logic                     dot_ge;

    ds_ctrl_t           ds_ctrl;
    logic [PROD_W-1:0]  ds_num;
    logic               ds_done;
    logic [ROOT_W-1:0]  ds_root;

    assign in_xfer   = items.valid && items.ready;
    assign ram_we    = in_xfer && (items.cmd == CMD_LOAD) &&
                       (32'(items.point_index) < 32'(MAX_POINTS));
    assign ram_waddr = AW'(items.point_index);
    assign rd_x      = $signed(ram_rdata[63:32]);
    assign rd_y      = $signed(ram_rdata[31:0]);

    always_comb
    begin
        case (state_reg)
            ST_ARD:  ram_raddr = il_reg[AW-1:0];
            ST_ALD:  ram_raddr = AW'(il_reg + 1'b1);
            default: ram_raddr = addr_reg[AW-1:0];
        endcase
    end

    pnd_ram #(
        .WIDTH (64),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({items.point_x, items.point_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pc_w   = NW'(point_count_reg);
    assign pc_cap = (pc_w < NW'(MAX_POINTS)) ? pc_w : NW'(MAX_POINTS);
    assign n_val  = pc_cap[CW-1:0];

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_GAIN:
            begin
                mul_a = $signed({4'b0, radius_reg});
                mul_b = $signed({5'b0, GAIN_Q30});
            end
            ST_MX:
            begin
                mul_a = ox_reg;
                mul_b = ox_reg;
            end
            ST_MY:
            begin
                mul_a = oy_reg;
                mul_b = oy_reg;
            end
            ST_P1:
            begin
                mul_a = ox_reg;
                mul_b = DIF_W'(sx_reg);
            end
            ST_P2:
            begin
                mul_a = oy_reg;
                mul_b = DIF_W'(sy_reg);
            end
            ST_P3:
            begin
                mul_a = DIF_W'(sx_reg);
                mul_b = DIF_W'(sx_reg);
            end
            ST_P4:
            begin
                mul_a = DIF_W'(sy_reg);
                mul_b = DIF_W'(sy_reg);
            end
            ST_OFX:
            begin
                mul_a = DIF_W'(sx_reg);
                mul_b = $signed({3'b0, t_reg});
            end
            ST_OFY:
            begin
                mul_a = DIF_W'(sy_reg);
                mul_b = $signed({3'b0, t_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // angle folded into [-pi/2, pi/2], start vector negated when folded
    always_comb
    begin
        ang_w = ANG_W'(angle_reg);
        if (ang_w > (ANG_W'(1) <<< 30))
        begin
            ang_red = ang_w - (ANG_W'(1) <<< 31);
            flip    = 1'b1;
        end
        else if (ang_w < -(ANG_W'(1) <<< 30))
        begin
            ang_red = ang_w + (ANG_W'(1) <<< 31);
            flip    = 1'b1;
        end
        else
        begin
            ang_red = ang_w;
            flip    = 1'b0;
        end
    end

    assign x0_pos = $signed({3'b0, prod[60:14]});
    assign x0     = flip ? -x0_pos : x0_pos;

    pnd_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_GAIN),
        .x0    (x0),
        .angle (ang_red),
        .done  (rot_done),
        .qx    (rot_qx),
        .qy    (rot_qy)
    );

    assign nxt_addr = addr_reg + CW'(2);
    assign better   = (addr_reg == '0) || (acc_reg[PROD_W-1:0] < best_reg);
    assign new_imin = better ? addr_reg : imin_reg;
    assign scan_end = (nxt_addr >= n_reg);

    // offset along the segment, truncated toward zero
    assign off_w   = prod + ((prod < 0) ? PROD_W'(32'hFFFFFFFF) : PROD_W'(0));
    assign off     = off_w[32 +: POS_W];
    assign dot_le0 = (dot_reg <= 0);
    assign dot_ge  = (dot_reg >= acc_reg);

    always_comb
    begin
        ds_ctrl.start = 1'b0;
        ds_ctrl.mode  = DS_SQRT;
        if (state_reg == ST_CLS && !dot_le0 && !dot_ge)
        begin
            ds_ctrl.start = 1'b1;
            ds_ctrl.mode  = DS_DIV;
        end
        else if (state_reg == ST_EV && ctx_reg == CTX_FIN)
        begin
            ds_ctrl.start = 1'b1;
        end
        ds_num = (ds_ctrl.mode == DS_DIV) ? dot_reg[PROD_W-1:0] : acc_reg[PROD_W-1:0];
    end

    pnd_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ds_ctrl),
        .num   (ds_num),
        .den   (acc_reg[PROD_W-1:0]),
        .done  (ds_done),
        .root  (ds_root)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && items.cmd == CMD_QUERY)
                begin
                    state_next = (n_val < CW'(2)) ? ST_OUT : ST_GAIN;
                end
            end
            ST_GAIN: state_next = ST_ROT;
            ST_ROT:
            begin
                if (rot_done)
                begin
                    state_next = ST_RD;
                    ctx_next   = CTX_SCAN;
                end
            end
            ST_RD:  state_next = ST_LD;
            ST_LD:  state_next = ST_MX;
            ST_MX:  state_next = ST_MY;
            ST_MY:  state_next = ST_EV;
            ST_EV:
            begin
                case (ctx_reg)
                    CTX_SCAN:
                    begin
                        if (!scan_end)
                        begin
                            state_next = ST_RD;
                        end
                        else if (new_imin == '0 || new_imin == n_reg - 1'b1)
                        begin
                            state_next = ST_ARD;
                        end
                        else
                        begin
                            state_next = ST_RD;
                            ctx_next   = CTX_LO;
                        end
                    end
                    CTX_LO:
                    begin
                        state_next = ST_RD;
                        ctx_next   = CTX_HI;
                    end
                    CTX_HI:  state_next = ST_ARD;
                    default: state_next = ST_SQRT;
                endcase
            end
            ST_ARD: state_next = ST_ALD;
            ST_ALD: state_next = ST_BLD;
            ST_BLD: state_next = ST_DIF;
            ST_DIF: state_next = ST_P1;
            ST_P1:  state_next = ST_P2;
            ST_P2:  state_next = ST_P3;
            ST_P3:  state_next = ST_P4;
            ST_P4:  state_next = ST_CLS;
            ST_CLS:
            begin
                if (dot_le0 || dot_ge)
                begin
                    state_next = ST_LD;
                    ctx_next   = CTX_FIN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (ds_done)
                begin
                    state_next = ST_OFX;
                end
            end
            ST_OFX: state_next = ST_OFY;
            ST_OFY:
            begin
                state_next = ST_LD;
                ctx_next   = CTX_FIN;
            end
            ST_SQRT:
            begin
                if (ds_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ctx_reg         <= CTX_SCAN;
            point_count_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            if (cfg_we)
            begin
                point_count_reg <= cfg_wdata;
            end
            if (state_reg == ST_OUT && (!res_valid_reg || results.ready))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                radius_reg   <= items.query_radius;
                angle_reg    <= items.query_angle;
                n_reg        <= n_val;
                pend_err_reg <= (n_val < CW'(2));
                addr_reg     <= '0;
            end
            ST_ROT:
            begin
                qx_reg <= rot_qx;
                qy_reg <= rot_qy;
            end
            ST_LD:
            begin
                if (ctx_reg == CTX_FIN)
                begin
                    ox_reg <= DIF_W'(qx_reg) - DIF_W'(px_reg);
                    oy_reg <= DIF_W'(qy_reg) - DIF_W'(py_reg);
                end
                else
                begin
                    ox_reg <= DIF_W'(qx_reg) - DIF_W'(rd_x);
                    oy_reg <= DIF_W'(qy_reg) - DIF_W'(rd_y);
                end
            end
            ST_MX: acc_reg <= ACC_W'(prod);
            ST_MY: acc_reg <= acc_reg + ACC_W'(prod);
            ST_EV:
            begin
                case (ctx_reg)
                    CTX_SCAN:
                    begin
                        if (better)
                        begin
                            best_reg <= acc_reg[PROD_W-1:0];
                        end
                        imin_reg <= new_imin;
                        if (!scan_end)
                        begin
                            addr_reg <= nxt_addr;
                        end
                        else if (new_imin == '0)
                        begin
                            il_reg <= '0;
                        end
                        else if (new_imin == n_reg - 1'b1)
                        begin
                            il_reg <= new_imin - 1'b1;
                        end
                        else
                        begin
                            addr_reg <= new_imin - 1'b1;
                        end
                    end
                    CTX_LO:
                    begin
                        best_reg <= acc_reg[PROD_W-1:0];
                        addr_reg <= imin_reg + 1'b1;
                    end
                    CTX_HI:
                    begin
                        // tie keeps the segment that starts at the best point
                        il_reg <= (best_reg < acc_reg[PROD_W-1:0]) ?
                                  (imin_reg - 1'b1) : imin_reg;
                    end
                    default:
                    begin
                        best_reg <= best_reg;
                    end
                endcase
            end
            ST_ALD:
            begin
                ax_reg <= rd_x;
                ay_reg <= rd_y;
            end
            ST_BLD:
            begin
                bx_reg <= rd_x;
                by_reg <= rd_y;
            end
            ST_DIF:
            begin
                sx_reg <= 33'(bx_reg) - 33'(ax_reg);
                sy_reg <= 33'(by_reg) - 33'(ay_reg);
                ox_reg <= DIF_W'(qx_reg) - DIF_W'(ax_reg);
                oy_reg <= DIF_W'(qy_reg) - DIF_W'(ay_reg);
            end
            ST_P1: acc_reg <= ACC_W'(prod);
            ST_P2: acc_reg <= acc_reg + ACC_W'(prod);
            ST_P3:
            begin
                dot_reg <= acc_reg;
                acc_reg <= ACC_W'(prod);
            end
            ST_P4: acc_reg <= acc_reg + ACC_W'(prod);
            ST_CLS:
            begin
                if (dot_le0)
                begin
                    kind_reg <= KIND_START;
                    px_reg   <= POS_W'(ax_reg);
                    py_reg   <= POS_W'(ay_reg);
                end
                else if (dot_ge)
                begin
                    kind_reg <= KIND_END;
                    px_reg   <= POS_W'(bx_reg);
                    py_reg   <= POS_W'(by_reg);
                end
                else
                begin
                    kind_reg <= KIND_INTERIOR;
                end
            end
            ST_DIV: t_reg <= ds_root[31:0];
            ST_OFX: px_reg <= POS_W'(ax_reg) + off;
            ST_OFY: py_reg <= POS_W'(ay_reg) + off;
            ST_SQRT:
            begin
                pend_dist_reg <= (|ds_root[ROOT_W-1:32]) ? 32'hFFFFFFFF : ds_root[31:0];
            end
            ST_OUT:
            begin
                if (!res_valid_reg || results.ready)
                begin
                    res_err_reg  <= pend_err_reg;
                    res_dist_reg <= pend_err_reg ? 32'd0 : pend_dist_reg;
                    res_seg_reg  <= pend_err_reg ? 11'd0 : 11'(il_reg);
                    res_kind_reg <= pend_err_reg ? KIND_INTERIOR : kind_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign items.ready           = (state_reg == ST_IDLE);
    assign results.valid         = res_valid_reg;
    assign results.distance      = res_dist_reg;
    assign results.segment_start = res_seg_reg;
    assign results.clamp_kind    = res_kind_reg;
    assign results.error         = res_err_reg;
endmodule

// ----- hdl/pnd_checker.sv -----
// ----------------------------------------------------------------------------
// pnd_checker
// Port-level checks of the distance block, bound to the top level.
// ----------------------------------------------------------------------------
module pnd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_cmd,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_distance,
    input logic [10:0] out_seg,
    input logic [1:0]  out_kind,
    input logic        out_error
);
    import pnd_pkg::*;

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_kind))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_distance == 32'd0 && out_seg == 11'd0 &&
        out_kind == KIND_INTERIOR)
        else $error("error result with nonzero fields");

    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind == KIND_INTERIOR || out_kind == KIND_START ||
        out_kind == KIND_END)
        else $error("bad clamp kind");

    // a query transfer makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_cmd == CMD_QUERY |=> !in_ready)
        else $error("ready after query transfer");
endmodule

bind polyline_nearest_distance_top pnd_checker u_pnd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_cmd       (items.cmd),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_distance (results.distance),
    .out_seg      (results.segment_start),
    .out_kind     (results.clamp_kind),
    .out_error    (results.error)
);

// ----- dv/tb_polyline_nearest_distance_top.sv -----
// ----------------------------------------------------------------------------
// tb_polyline_nearest_distance_top
// Self-checking bench for the point to polyline distance block. Loads random
// polylines, sets the point count between phases and runs distance queries
// against a bit-accurate predictor; results are checked in order.
// ----------------------------------------------------------------------------
module tb_polyline_nearest_distance_top;
    import pnd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [127:0] u128_t;

    typedef struct {
        logic               cmd;
        logic [10:0]        idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [30:0]        rad;
        logic signed [31:0] ang;
    } item_t;

    typedef struct {
        logic [31:0] distance;
        logic [10:0] seg;
        logic [1:0]  kind;
        logic        err;
    } dist_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_wdata;

    pnd_item_if   item_ch ();
    pnd_result_if res_ch ();

    polyline_nearest_distance_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (item_ch.sink),
        .results   (res_ch.source)
    );

    item_t              pending_items[$];
    dist_result_t       expected_results[$];
    logic signed [31:0] x_mem [2048];
    logic signed [31:0] y_mem [2048];
    logic [11:0]        point_limit;
    int                 mismatches;
    bit                 quiet;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic u128_t sq_mag(longint d);
        longint unsigned m = abs64(d);
        return u128_t'(m) * u128_t'(m);
    endfunction

    function automatic u128_t dist2(longint ax, longint ay, longint bx, longint by);
        return sq_mag(ax - bx) + sq_mag(ay - by);
    endfunction

    function automatic longint along(longint d, logic [31:0] t);
        u128_t  p = u128_t'(abs64(d)) * u128_t'(t);
        longint m = longint'(p[95:32]);
        return d < 0 ? -m : m;
    endfunction

    function automatic void polar_to_pos(input logic [30:0] rad, input logic signed [31:0] ang,
                                         output longint qx, output longint qy);
        longint          a, x, y, z, sx, sy;
        longint unsigned prod;
        bit              flip;
        a    = longint'(ang);
        y    = 0;
        flip = 0;
        if (a > (longint'(1) << 30)) begin
            a    = a - (longint'(1) << 31);
            flip = 1;
        end
        else if (a < -(longint'(1) << 30)) begin
            a    = a + (longint'(1) << 31);
            flip = 1;
        end
        prod = 64'(rad) * 64'(GAIN_Q30);
        x    = longint'(prod >> (30 - GUARD_BITS));
        if (flip)
            x = -x;
        z = a;
        for (int i = 0; i < ROT_STEPS; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (z >= 0) begin
                x = x - sx;
                y = y + sy;
                z = z - longint'(ROT_ANGLE[i]);
            end
            else begin
                x = x + sx;
                y = y - sy;
                z = z + longint'(ROT_ANGLE[i]);
            end
        end
        qx = (x + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
        qy = (y + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
    endfunction

    function automatic dist_result_t nearest_distance(logic [30:0] rad, logic signed [31:0] ang);
        dist_result_t       r;
        int                 n, imin, il;
        longint             qx, qy, ax, ay, bx, by, sx, sy, dx, dy, px, py;
        u128_t              best, w, lo_d, hi_d, len2, root, cand, t;
        logic signed [127:0] dot;
        r  = '{distance: '0, seg: '0, kind: KIND_INTERIOR, err: 1'b0};
        n  = point_limit > 2048 ? 2048 : int'(point_limit);
        if (n < 2) begin
            r.err = 1'b1;
            return r;
        end
        polar_to_pos(rad, ang, qx, qy);
        imin = 0;
        best = '0;
        for (int i = 0; i < n; i += 2) begin
            w = dist2(qx, qy, x_mem[i], y_mem[i]);
            if (i == 0 || w < best) begin
                best = w;
                imin = i;
            end
        end
        if (imin == 0)
            il = 0;
        else if (imin == n - 1)
            il = imin - 1;
        else begin
            lo_d = dist2(qx, qy, x_mem[imin - 1], y_mem[imin - 1]);
            hi_d = dist2(qx, qy, x_mem[imin + 1], y_mem[imin + 1]);
            il   = lo_d < hi_d ? imin - 1 : imin;
        end
        ax   = x_mem[il];
        ay   = y_mem[il];
        bx   = x_mem[il + 1];
        by   = y_mem[il + 1];
        sx   = bx - ax;
        sy   = by - ay;
        dx   = qx - ax;
        dy   = qy - ay;
        dot  = 128'(dx) * 128'(sx) + 128'(dy) * 128'(sy);
        len2 = sq_mag(sx) + sq_mag(sy);
        if (dot <= 0) begin
            r.kind = KIND_START;
            px     = ax;
            py     = ay;
        end
        else if (dot >= $signed(len2)) begin
            r.kind = KIND_END;
            px     = bx;
            py     = by;
        end
        else begin
            r.kind = KIND_INTERIOR;
            t      = (u128_t'(dot) << 32) / len2;
            px     = ax + along(sx, t[31:0]);
            py     = ay + along(sy, t[31:0]);
        end
        w    = dist2(qx, qy, px, py);
        root = '0;
        for (int b = 34; b >= 0; b--) begin
            cand = root | (u128_t'(1) << b);
            if (cand * cand <= w)
                root = cand;
        end
        r.distance = root > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : root[31:0];
        r.seg      = il[10:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Item driver
    // ------------------------------------------------------------------
    int  gap_left;
    bit  drv_calm;
    int  drv_cycle;

    always @(posedge clk or negedge rst_n)
    begin
        item_t it;
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
            gap_left      = 0;
            drv_cycle     = 0;
            drv_calm      = 0;
        end
        else begin
            drv_cycle++;
            if (drv_cycle % 300 == 0)
                drv_calm = ($urandom_range(0, 2) == 0);
            if (item_ch.valid && item_ch.ready) begin
                if (item_ch.cmd == CMD_LOAD) begin
                    x_mem[item_ch.point_index] = item_ch.point_x;
                    y_mem[item_ch.point_index] = item_ch.point_y;
                end
                else
                    expected_results.push_back(
                        nearest_distance(item_ch.query_radius, item_ch.query_angle));
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    item_ch.valid <= 1'b0;
                else if (!quiet && !drv_calm && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(1, 12) - 1;
                    item_ch.valid <= 1'b0;
                end
                else begin
                    it = pending_items.pop_front();
                    item_ch.valid        <= 1'b1;
                    item_ch.cmd          <= it.cmd;
                    item_ch.point_index  <= it.idx;
                    item_ch.point_x      <= it.px;
                    item_ch.point_y      <= it.py;
                    item_ch.query_radius <= it.rad;
                    item_ch.query_angle  <= it.ang;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    int  stall_left;
    bit  mon_calm;
    int  mon_cycle;

    always @(posedge clk or negedge rst_n)
    begin
        dist_result_t want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   = 0;
            mon_cycle    = 0;
            mon_calm     = 0;
        end
        else begin
            mon_cycle++;
            if (mon_cycle % 250 == 0)
                mon_calm = ($urandom_range(0, 2) == 0);
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result dist=%h seg=%0d kind=%0d err=%0b",
                                 $realtime, res_ch.distance, res_ch.segment_start,
                                 res_ch.clamp_kind, res_ch.error);
                end
                else begin
                    want = expected_results.pop_front();
                    if (res_ch.distance !== want.distance || res_ch.segment_start !== want.seg
                        || res_ch.clamp_kind !== want.kind || res_ch.error !== want.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch exp dist=%h seg=%0d kind=%0d err=%0b",
                                      " got dist=%h seg=%0d kind=%0d err=%0b"},
                                     $realtime, want.distance, want.seg, want.kind, want.err,
                                     res_ch.distance, res_ch.segment_start,
                                     res_ch.clamp_kind, res_ch.error);
                    end
                end
            end
            if (quiet || mon_calm)
                res_ch.ready <= 1'b1;
            else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_load(int idx, logic signed [31:0] x, logic signed [31:0] y);
        item_t it;
        it = '{cmd: CMD_LOAD, idx: idx[10:0], px: x, py: y,
               rad: 31'($urandom), ang: $urandom};
        pending_items.push_back(it);
    endtask

    task automatic push_query(logic [30:0] rad, logic signed [31:0] ang);
        item_t it;
        it = '{cmd: CMD_QUERY, idx: 11'($urandom), px: $urandom, py: $urandom,
               rad: rad, ang: ang};
        pending_items.push_back(it);
    endtask

    // block is idle once everything is sent and answered; loads need a little more
    task automatic drain();
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(logic [11:0] v);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        point_limit = v;
        @(posedge clk);
        cfg_we      <= 1'b0;
    endtask

    function automatic logic signed [31:0] coord(int k);
        return $signed($urandom) >>> (31 - k);
    endfunction

    // polyline at scale 2^k, with repeated points now and then
    task automatic load_polyline(int n, int k);
        logic signed [31:0] x, y;
        x = coord(k);
        y = coord(k);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) != 0) begin
                x = coord(k);
                y = coord(k);
            end
            push_load(i, x, y);
        end
    endtask

    task automatic random_queries(int cnt, int k);
        logic [30:0] r;
        for (int q = 0; q < cnt; q++) begin
            r = 31'($urandom >> (32 - k));
            if ($urandom_range(0, 9) == 0)
                r = 31'($urandom);
            push_query(r, $urandom);
        end
    endtask

    initial
    begin
        int n, k;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        point_limit   = '0;
        mismatches    = 0;
        quiet         = 0;
        item_ch.valid = 1'b0;
        item_ch.cmd   = CMD_LOAD;
        item_ch.point_index  = '0;
        item_ch.point_x      = '0;
        item_ch.point_y      = '0;
        item_ch.query_radius = '0;
        item_ch.query_angle  = '0;
        res_ch.ready  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // too few points after reset, then with a count of one
        push_query(31'h10000, 32'h0);
        drain();
        write_count(12'd1);
        push_query(31'h7FFF_FFFF, 32'h4000_0000);
        drain();

        // extremes, a zero-length segment, a tie between neighbours
        push_load(0, 32'sh8000_0000, 32'sh8000_0000);
        push_load(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_load(2, 32'sh0001_0000, 32'sh0);
        push_load(3, 32'sh0001_0000, 32'sh0);
        push_load(4, 32'sh0, 32'sh0001_0000);
        push_load(2047, 32'sh7FFF_FFFF, 32'sh8000_0000);
        drain();
        write_count(12'd5);
        push_query(31'h0, 32'h0);
        push_query(31'h7FFF_FFFF, 32'h0);
        push_query(31'h0001_0000, 32'h4000_0000);
        push_query(31'h0001_0000, 32'hC000_0000);
        push_query(31'h0001_0000, 32'h4000_0001);
        push_query(31'h0001_0000, 32'hBFFF_FFFF);
        push_query(31'h0002_0000, 32'h8000_0000);
        push_query(31'h0002_0000, 32'h7FFF_FFFF);
        push_query(31'h7FFF_FFFF, 32'hA000_0000);
        push_query(31'h0000_8000, 32'h2000_0000);
        drain();

        // longer table, even and odd counts
        for (int i = 0; i < 200; i++)
            push_load(i, coord(20), coord(20));
        drain();
        write_count(12'd200);
        random_queries(2, 20);
        drain();
        write_count(12'd199);
        random_queries(2, 20);
        drain();

        // random phases, mostly short polylines
        for (int ph = 0; ph < 12; ph++) begin
            n = $urandom_range(2, 40);
            k = $urandom_range(4, 31);
            if (ph == 11)
                quiet = 1;
            load_polyline(n, k);
            drain();
            if (ph == 6)
                write_count(12'd0);
            else
                write_count(n[11:0]);
            random_queries(16, k);
            drain();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
